// ===== hw/rtl/sldt_pkg.sv =====
`default_nettype none

package sldt_pkg;

  // fixed field widths
  localparam int unsigned SEQ_W = 32;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned CAP_W = 17;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W = 1;

  // bitmap defaults
  localparam int unsigned MAX_TRACKED_DEF = 65536;
  localparam int unsigned WORD_BITS_DEF = 64;

  // register reset values
  localparam logic [CAP_W-1:0] CAPACITY_RST = CAP_W'(65536);
  localparam logic [SEQ_W-1:0] WINDOW_BASE_RST = '0;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BASE = 1'b1;

  // request codes
  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // result verdicts
  typedef enum logic [1:0] {
    VERDICT_NEW   = 2'd0,
    VERDICT_DUP   = 2'd1,
    VERDICT_OOR   = 2'd2,
    VERDICT_STATS = 2'd3
  } verdict_e;

endpackage

`default_nettype wire

// ===== hw/rtl/sequence_loss_duplicate_tracker_unit.sv =====
// channel  | direction | signals                                        | handshake
// ---------+-----------+------------------------------------------------+---------------------
// request  | in        | req_type_i, seq_value_i, expected_count_i      | start & !busy
// result   | out       | verdict_o, received_count_o, lost_count_o,     | valid_o, one cycle
//          |           | duplicate_count_o, out_of_range_count_o        |
// config   | in        | cfg_index_i, cfg_data_i                        | cfg_valid_i & cfg_ready_o
//
// a record word passes range check, reciprocal multiply, remainder fix with bitmap read,
// then bit test and write back, before the next request can be accepted.
// a query or out-of-range record ends at the range check; the result strobe rises as busy falls.
// after reset the bitmap is cleared one word per cycle over all MAX_TRACKED/WORD_BITS words
// (1024 at defaults), with busy held high; configuration writes are taken throughout.
// the result receiver cannot stall: valid_o is a single-cycle strobe.
`default_nettype none

module sequence_loss_duplicate_tracker_unit
  import sldt_pkg::*;
#(
  parameter int unsigned MAX_TRACKED = MAX_TRACKED_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // request
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  req_type_i,
  input  wire logic [SEQ_W-1:0]      seq_value_i,
  input  wire logic [CNT_W-1:0]      expected_count_i,
  // result
  output logic                       valid_o,
  output verdict_e                   verdict_o,
  output logic      [CNT_W-1:0]      received_count_o,
  output logic      [CNT_W-1:0]      lost_count_o,
  output logic      [CNT_W-1:0]      duplicate_count_o,
  output logic      [CNT_W-1:0]      out_of_range_count_o,
  // configuration
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned NUM_WORDS = (MAX_TRACKED + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned ADDR_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned OFF_W = $clog2(MAX_TRACKED);
  localparam int unsigned BIT_W = $clog2(WORD_BITS);
  localparam int unsigned PROD_W = 2 * OFF_W;
  localparam logic [OFF_W-1:0] RECIP = OFF_W'((64'd1 << OFF_W) / WORD_BITS);
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(NUM_WORDS - 1);
  localparam logic [SEQ_W-1:0] MAX_SEQ = SEQ_W'(MAX_TRACKED);
  localparam logic [OFF_W-1:0] WORD_OFF = OFF_W'(WORD_BITS);
  localparam logic [WORD_BITS-1:0] ONE_HOT0 = WORD_BITS'(1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RANGE,
    S_MUL,
    S_FIX,
    S_UPD
  } state_e;

  state_e              state_q;
  logic [ADDR_W-1:0]   clr_q;
  logic                req_q;
  logic [SEQ_W-1:0]    seq_q;
  logic [CNT_W-1:0]    expected_q;
  logic [OFF_W-1:0]    off_q;
  logic [PROD_W-1:0]   prod_q;
  logic [ADDR_W-1:0]   word_q;
  logic [BIT_W-1:0]    bit_q;
  logic [CAP_W-1:0]    cap_q;
  logic [SEQ_W-1:0]    base_q;
  logic [CNT_W-1:0]    received_q;
  logic [CNT_W-1:0]    duplicate_q;
  logic [CNT_W-1:0]    oor_q;

  logic [SEQ_W-1:0]    offset;
  logic                in_range;
  logic [ADDR_W-1:0]   quot0;
  logic [OFF_W-1:0]    rem0;
  logic                rem_over;
  logic [ADDR_W-1:0]   quot;
  logic [OFF_W-1:0]    rem;
  logic [WORD_BITS-1:0] rd_word;
  logic [WORD_BITS-1:0] bit_mask;
  logic                bit_set;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                ram_re;

  assign busy = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // offset from window base and range check against the saturated capacity
  assign offset = seq_q - base_q;
  assign in_range = (offset < SEQ_W'(cap_q)) && (offset < MAX_SEQ);

  // word index by reciprocal multiply, then one correction step
  assign quot0 = ADDR_W'(prod_q[PROD_W-1:OFF_W]);
  assign rem0 = off_q - OFF_W'(quot0 * WORD_BITS);
  assign rem_over = (rem0 >= WORD_OFF);
  assign quot = rem_over ? quot0 + ADDR_W'(1) : quot0;
  assign rem = rem_over ? rem0 - WORD_OFF : rem0;

  // bit test on the word read back
  assign bit_mask = ONE_HOT0 << bit_q;
  assign bit_set = |(rd_word & bit_mask);

  // bitmap port control: clearing sweep or read-modify-write
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = word_q;
    ram_wdata = rd_word | bit_mask;
    if (state_q == S_CLEAR) begin
      ram_we = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else if (state_q == S_UPD) begin
      ram_we = !bit_set;
    end
  end

  assign ram_re = (state_q == S_FIX);

  sldt_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (quot),
    .rdata_o (rd_word)
  );

  // control, counters and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      req_q <= REQ_RECORD;
      seq_q <= '0;
      expected_q <= '0;
      off_q <= '0;
      prod_q <= '0;
      word_q <= '0;
      bit_q <= '0;
      cap_q <= CAPACITY_RST;
      base_q <= WINDOW_BASE_RST;
      received_q <= '0;
      duplicate_q <= '0;
      oor_q <= '0;
      valid_o <= 1'b0;
      verdict_o <= VERDICT_NEW;
      received_count_o <= '0;
      lost_count_o <= '0;
      duplicate_count_o <= '0;
      out_of_range_count_o <= '0;
    end else begin
      // register writes
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_CAPACITY:    cap_q <= cfg_data_i[CAP_W-1:0];
          CFG_WINDOW_BASE: base_q <= cfg_data_i[SEQ_W-1:0];
          default: ;
        endcase
      end

      unique case (state_q)
        S_CLEAR: begin
          valid_o <= 1'b0;
          clr_q <= clr_q + ADDR_W'(1);
          if (clr_q == LAST_IDX) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          valid_o <= 1'b0;
          if (start) begin
            req_q <= req_type_i;
            seq_q <= seq_value_i;
            expected_q <= expected_count_i;
            state_q <= S_RANGE;
          end
        end
        S_RANGE: begin
          off_q <= offset[OFF_W-1:0];
          if (req_q == REQ_QUERY) begin
            valid_o <= 1'b1;
            verdict_o <= VERDICT_STATS;
            received_count_o <= received_q;
            lost_count_o <= expected_q - received_q;
            duplicate_count_o <= duplicate_q;
            out_of_range_count_o <= oor_q;
            state_q <= S_IDLE;
          end else if (!in_range) begin
            oor_q <= oor_q + CNT_W'(1);
            valid_o <= 1'b1;
            verdict_o <= VERDICT_OOR;
            received_count_o <= received_q;
            lost_count_o <= '0;
            duplicate_count_o <= duplicate_q;
            out_of_range_count_o <= oor_q + CNT_W'(1);
            state_q <= S_IDLE;
          end else begin
            valid_o <= 1'b0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          valid_o <= 1'b0;
          prod_q <= PROD_W'(off_q) * PROD_W'(RECIP);
          state_q <= S_FIX;
        end
        S_FIX: begin
          valid_o <= 1'b0;
          word_q <= quot;
          bit_q <= BIT_W'(rem);
          state_q <= S_UPD;
        end
        S_UPD: begin
          valid_o <= 1'b1;
          lost_count_o <= '0;
          out_of_range_count_o <= oor_q;
          if (bit_set) begin
            duplicate_q <= duplicate_q + CNT_W'(1);
            verdict_o <= VERDICT_DUP;
            received_count_o <= received_q;
            duplicate_count_o <= duplicate_q + CNT_W'(1);
          end else begin
            received_q <= received_q + CNT_W'(1);
            verdict_o <= VERDICT_NEW;
            received_count_o <= received_q + CNT_W'(1);
            duplicate_count_o <= duplicate_q;
          end
          state_q <= S_IDLE;
        end
        default: begin
          valid_o <= 1'b0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // a result only ever follows the range stage or the update stage
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($past(state_q) == S_RANGE || $past(state_q) == S_UPD))
    else $error("result strobe without a finishing stage");

  // a new verdict moves the received counter by exactly one
  a_new_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && verdict_o == VERDICT_NEW) |-> received_q == $past(received_q) + CNT_W'(1))
    else $error("received counter out of step with verdict");

  // the write back goes to the word that was read
  a_rmw_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> (word_q == $past(quot)))
    else $error("bitmap write back address differs from read address");

  // the reported received count tracks the counter
  a_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (received_count_o == received_q))
    else $error("reported received count differs from counter");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/sldt_ram.sv =====
`default_nettype none

module sldt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== verif/sequence_loss_duplicate_tracker_unit_tb.sv =====
`timescale 1ns / 100ps

module sequence_loss_duplicate_tracker_unit_tb;
  import sldt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned BITMAP_BITS = MAX_TRACKED_DEF;
  localparam int unsigned PHASE_WORDS = 148;
  localparam int unsigned MAX_REPORTS = 10;

  // one result word as the tracker should present it
  typedef struct {
    verdict_e         verdict;
    logic [CNT_W-1:0] received;
    logic [CNT_W-1:0] lost;
    logic [CNT_W-1:0] duplicates;
    logic [CNT_W-1:0] out_of_range;
  } tracker_answer_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic                  req_type_i;
  logic [SEQ_W-1:0]      seq_value_i;
  logic [CNT_W-1:0]      expected_count_i;
  logic                  valid_o;
  verdict_e              verdict_o;
  logic [CNT_W-1:0]      received_count_o;
  logic [CNT_W-1:0]      lost_count_o;
  logic [CNT_W-1:0]      duplicate_count_o;
  logic [CNT_W-1:0]      out_of_range_count_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // shadow of the tracker state and its registers
  bit               seen_offsets [BITMAP_BITS];
  logic [CNT_W-1:0] received_tot;
  logic [CNT_W-1:0] duplicate_tot;
  logic [CNT_W-1:0] oor_tot;
  logic [CAP_W-1:0] capacity_reg;
  logic [SEQ_W-1:0] window_base_reg;

  tracker_answer_t pending_answers[$];
  int unsigned     mismatch_count = 0;
  int unsigned     cycle_count = 0;
  bit              idle_bursts_on;

  sequence_loss_duplicate_tracker_unit uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start                (start),
    .busy                 (busy),
    .req_type_i           (req_type_i),
    .seq_value_i          (seq_value_i),
    .expected_count_i     (expected_count_i),
    .valid_o              (valid_o),
    .verdict_o            (verdict_o),
    .received_count_o     (received_count_o),
    .lost_count_o         (lost_count_o),
    .duplicate_count_o    (duplicate_count_o),
    .out_of_range_count_o (out_of_range_count_o),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i)
  );

  // 10 ns clock
  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // tracked span, capacity saturates at the bitmap size
  function automatic logic [CAP_W-1:0] tracked_span();
    if (capacity_reg > CAP_W'(MAX_TRACKED_DEF)) begin
      return CAP_W'(MAX_TRACKED_DEF);
    end
    return capacity_reg;
  endfunction

  // classify one accepted word and update the shadow counters
  function automatic tracker_answer_t tally_request(input logic req,
                                                    input logic [SEQ_W-1:0] seq,
                                                    input logic [CNT_W-1:0] exp_cnt);
    tracker_answer_t  ans;
    logic [SEQ_W-1:0] offset;
    ans.lost = '0;
    if (req == REQ_QUERY) begin
      ans.verdict = VERDICT_STATS;
      ans.lost = exp_cnt - received_tot;
    end else begin
      offset = seq - window_base_reg;
      if (offset >= SEQ_W'(tracked_span())) begin
        oor_tot = oor_tot + 1;
        ans.verdict = VERDICT_OOR;
      end else if (seen_offsets[offset]) begin
        duplicate_tot = duplicate_tot + 1;
        ans.verdict = VERDICT_DUP;
      end else begin
        seen_offsets[offset] = 1'b1;
        received_tot = received_tot + 1;
        ans.verdict = VERDICT_NEW;
      end
    end
    ans.received = received_tot;
    ans.duplicates = duplicate_tot;
    ans.out_of_range = oor_tot;
    return ans;
  endfunction

  function automatic void check_field(input string field, input logic [CNT_W-1:0] want,
                                      input logic [CNT_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("mismatch on %s: expected %0h, got %0h", field, want, got);
      end
    end
  endfunction

  // compare each result word with the oldest prediction
  always @(posedge clk_i) begin : answer_check
    tracker_answer_t ans;
    if (rst_ni && valid_o) begin
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected result word, verdict %0d", verdict_o);
        end
      end else begin
        ans = pending_answers.pop_front();
        check_field("verdict", CNT_W'(ans.verdict), CNT_W'(verdict_o));
        check_field("received_count", ans.received, received_count_o);
        check_field("lost_count", ans.lost, lost_count_o);
        check_field("duplicate_count", ans.duplicates, duplicate_count_o);
        check_field("out_of_range_count", ans.out_of_range, out_of_range_count_o);
      end
    end
  end

  // send one word; the field that the request ignores carries random data
  task automatic send_word(input logic req, input logic [CNT_W-1:0] operand);
    int unsigned gap;
    @(negedge clk_i);
    if (idle_bursts_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start = 1'b1;
    req_type_i = req;
    if (req == REQ_QUERY) begin
      seq_value_i = $urandom;
      expected_count_i = operand;
    end else begin
      seq_value_i = operand;
      expected_count_i = $urandom;
    end
    do @(posedge clk_i); while (busy);
    pending_answers.push_back(tally_request(req, seq_value_i, expected_count_i));
  endtask

  // stop sending until every predicted word has come back
  task automatic wait_for_answers();
    @(negedge clk_i);
    start = 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_CAPACITY) begin
      capacity_reg = data[CAP_W-1:0];
    end else begin
      window_base_reg = data;
    end
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // reset registers: first and last offset, just past the end, queries with wrapping loss
  task automatic test_default_window();
    send_word(REQ_RECORD, 32'h0000_0000);
    send_word(REQ_RECORD, 32'h0000_0000);
    send_word(REQ_RECORD, 32'h0000_FFFF);
    send_word(REQ_RECORD, 32'h0001_0000);
    send_word(REQ_RECORD, 32'hFFFF_FFFF);
    send_word(REQ_QUERY, 32'h0000_0000);
    send_word(REQ_QUERY, 32'hFFFF_FFFF);
    send_word(REQ_QUERY, received_tot);
  endtask

  // window straddling the 32-bit wrap, bitmap and counters kept over the writes
  task automatic test_window_wraparound();
    wait_for_answers();
    write_register(CFG_WINDOW_BASE, 32'hFFFF_FF00);
    write_register(CFG_CAPACITY, 32'd512);
    send_word(REQ_RECORD, 32'hFFFF_FF00);
    send_word(REQ_RECORD, 32'h0000_00FF);
    send_word(REQ_RECORD, 32'h0000_0100);
    send_word(REQ_RECORD, 32'hFFFF_FEFF);
    send_word(REQ_QUERY, 32'h0000_0005);
  endtask

  // zero capacity, capacity above the bitmap size, single offset
  task automatic test_capacity_limits();
    wait_for_answers();
    write_register(CFG_CAPACITY, 32'd0);
    send_word(REQ_RECORD, 32'hFFFF_FF00);
    wait_for_answers();
    write_register(CFG_CAPACITY, 32'hFFFF_FFFF);
    send_word(REQ_RECORD, window_base_reg + 32'h0000_FFFF);
    send_word(REQ_RECORD, window_base_reg + 32'h0001_0000);
    wait_for_answers();
    write_register(CFG_WINDOW_BASE, 32'h8000_0000);
    write_register(CFG_CAPACITY, 32'd1);
    send_word(REQ_RECORD, 32'h8000_0000);
    send_word(REQ_RECORD, 32'h8000_0001);
    send_word(REQ_QUERY, 32'h7FFF_FFFF);
  endtask

  // phases of mostly in-window traffic with duplicates, queries and noise
  task automatic test_random_traffic();
    logic [CAP_W-1:0]  cap_pick;
    logic [CNT_W-1:0]  operand;
    int unsigned       span;
    int unsigned       pick;
    int unsigned       ofs;
    for (int phase = 0; phase < 9; phase++) begin
      wait_for_answers();
      case (phase)
        0: cap_pick = CAP_W'(65536);
        1: cap_pick = '0;
        2: cap_pick = '1;
        3: cap_pick = CAP_W'(64);
        5: cap_pick = CAP_W'(1);
        7: cap_pick = CAP_W'(65535);
        default: cap_pick = CAP_W'($urandom);
      endcase
      write_register(CFG_CAPACITY, {15'($urandom), cap_pick});
      if (phase % 2 == 0) begin
        write_register(CFG_WINDOW_BASE, $urandom);
      end else begin
        write_register(CFG_WINDOW_BASE, 32'hFFFF_FFFF - $urandom_range(0, 300));
      end
      // the last phase runs back to back
      idle_bursts_on = (phase != 8);
      span = tracked_span();
      repeat (PHASE_WORDS) begin
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          if (pick < 6) begin
            operand = received_tot + $urandom_range(0, 40) - 20;
          end else begin
            operand = $urandom;
          end
          send_word(REQ_QUERY, operand);
        end else if (pick < 88 && span != 0) begin
          if (pick >= 85) begin
            ofs = (pick == 85) ? span - 1 : span;
          end else if (pick < 55) begin
            ofs = $urandom_range(0, ((span < 96) ? span : 96) - 1);
          end else begin
            ofs = $urandom_range(0, span - 1);
          end
          send_word(REQ_RECORD, window_base_reg + ofs);
        end else begin
          send_word(REQ_RECORD, $urandom);
        end
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    req_type_i = REQ_RECORD;
    seq_value_i = '0;
    expected_count_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_CAPACITY;
    cfg_data_i = '0;
    received_tot = '0;
    duplicate_tot = '0;
    oor_tot = '0;
    capacity_reg = CAPACITY_RST;
    window_base_reg = WINDOW_BASE_RST;
    idle_bursts_on = 1'b1;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_window();
    test_window_wraparound();
    test_capacity_limits();
    test_random_traffic();

    wait_for_answers();
    repeat (12) @(posedge clk_i);
    if (mismatch_count == 0 && pending_answers.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
